// ===== rtl/msa_pkg.sv =====
// Shared types and constants of the multichannel sample averager.
`timescale 1ns / 1ps

package msa_pkg;

   // Fixed widths of the item fields.
   localparam int CHANNEL_BITS = 3;
   localparam int SAMPLE_FIELD_BITS = 12;
   localparam int AVERAGE_BITS = 12;

   // Command codes carried in the cmd field of an input item.
   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_AVERAGE = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_FLUSH,
      ST_DIVIDE,
      ST_FINISH
   } msa_state_type;

endpackage

// ===== rtl/msa_req_if.sv =====
// Request channel carrying store and average commands.
`timescale 1ns / 1ps

interface msa_req_if;
   import msa_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [CHANNEL_BITS-1:0]      channel;
   logic [SAMPLE_FIELD_BITS-1:0] sample;

   modport source (output valid, output cmd, output channel, output sample, input ready);
   modport sink (input valid, input cmd, input channel, input sample, output ready);
endinterface

// ===== rtl/msa_rsp_if.sv =====
// Response channel carrying channel averages.
`timescale 1ns / 1ps

interface msa_rsp_if;
   import msa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [AVERAGE_BITS-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink (input valid, input average, output ready);
endinterface

// ===== rtl/multichannel_sample_averager_core.sv =====
// Multichannel moving-average sample store with a shared accumulator and divider.
`timescale 1ns / 1ps

// Each channel keeps a ring of RING_DEPTH samples in a single synchronous sample
// memory. A store item writes the sample at the channel's write position, which
// then advances and wraps. An average item reads the channel's whole ring
// through the one memory read port, one entry per cycle, and adds each entry
// into an accumulator; a flush state adds the last entry. When RING_DEPTH is a
// power of two the mean is a plain shift; otherwise a divide state multiplies
// by the scaled reciprocal of the depth. A finish state then loads the output
// register. The memory is never swept after reset: every channel writes its
// ring in order from position zero, so an entry at or beyond the write
// position of a channel that has not yet wrapped is known to be empty and
// reads as zero. Store items are taken while an earlier average is still
// waiting in the output register; a new average item is taken once the block
// is back in its idle state. A channel index of NUM_CHANNELS or above is
// ignored by a store and answered with an average of zero by a read.
module multichannel_sample_averager_core #(
   parameter int NUM_CHANNELS = 8,
   parameter int RING_DEPTH = 16,
   parameter int SAMPLE_BITS = 12
) (
   input logic      clock,
   input logic      reset,
   msa_req_if.sink  req_if,
   msa_rsp_if.source rsp_if
);
   import msa_pkg::*;

   localparam int MEM_DEPTH = NUM_CHANNELS * RING_DEPTH;
   localparam int ADDR_W = $clog2(MEM_DEPTH);
   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int POS_W = $clog2(RING_DEPTH);
   localparam int LOG_D = $clog2(RING_DEPTH);
   localparam int SUM_W = SAMPLE_BITS + LOG_D;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W = SUM_W + RECIP_W;
   localparam int MUL_SHIFT = SUM_W + LOG_D;
   localparam bit DEPTH_IS_POW2 = ((RING_DEPTH & (RING_DEPTH - 1)) == 0);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(RING_DEPTH - 1);
   // Rounded-up reciprocal of the depth, exact for every possible sum.
   localparam longint unsigned RECIP_WIDE =
      ((64'd1 << MUL_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);

   // Sample memory, one synchronous read port and one write port.
   logic [SAMPLE_BITS-1:0] sample_mem [MEM_DEPTH];
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [SAMPLE_BITS-1:0] wr_data;
   logic [ADDR_W-1:0]      rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   // Per-channel write position and a flag set once the ring has wrapped.
   logic [POS_W-1:0]        wpos_ff [NUM_CHANNELS];
   logic [POS_W-1:0]        wpos_in;
   logic [NUM_CHANNELS-1:0] full_ff;
   logic                    full_in;
   logic                    pos_wr_en;

   msa_state_type           state_ff, state_in;
   logic [ADDR_W-1:0]       base_ff, base_in;
   logic [POS_W-1:0]        lim_ff, lim_in;
   logic                    wrapped_ff, wrapped_in;
   logic [POS_W-1:0]        idx_ff, idx_in;
   logic                    take_ff, take_in;
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic [SAMPLE_BITS-1:0]  quo_ff, quo_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [AVERAGE_BITS-1:0] avg_ff, avg_in;

   logic                    req_fire;
   logic                    in_range;
   logic [CH_W-1:0]         req_ch;
   logic [ADDR_W-1:0]       req_base;
   logic [POS_W-1:0]        req_pos;
   logic [SUM_W-1:0]        acc_sum;
   logic [PROD_W-1:0]       recip_prod;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.average = avg_ff;

   assign in_range = (int'(req_if.channel) < NUM_CHANNELS);
   assign req_ch = CH_W'(req_if.channel);
   assign req_base = ADDR_W'(req_ch) * ADDR_W'(RING_DEPTH);
   assign req_pos = wpos_ff[req_ch];

   // Entry fetched in the previous cycle joins the running sum if it has been written.
   assign acc_sum = acc_ff + (take_ff ? SUM_W'(rd_data_ff) : SUM_W'(0));

   // Sum times the scaled reciprocal; the bits above MUL_SHIFT are the quotient.
   assign recip_prod = PROD_W'(acc_ff) * PROD_W'(RECIP);

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      lim_in = lim_ff;
      wrapped_in = wrapped_ff;
      idx_in = idx_ff;
      take_in = 1'b0;
      acc_in = acc_ff;
      quo_in = quo_ff;
      avg_in = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      wr_en = 1'b0;
      wr_addr = req_base + ADDR_W'(req_pos);
      wr_data = SAMPLE_BITS'(req_if.sample);
      pos_wr_en = 1'b0;
      wpos_in = (req_pos == LAST_POS) ? '0 : req_pos + POS_W'(1);
      full_in = (req_pos == LAST_POS);
      rd_addr = base_ff + ADDR_W'(idx_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.cmd == CMD_STORE) begin
                  wr_en = in_range;
                  pos_wr_en = in_range;
               end else if (in_range) begin
                  base_in = req_base;
                  lim_in = req_pos;
                  wrapped_in = full_ff[req_ch];
                  idx_in = '0;
                  acc_in = '0;
                  state_in = ST_SUM;
               end else begin
                  quo_in = '0;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SUM: begin
            // Issue one read per cycle; the data is added in the next cycle.
            take_in = wrapped_ff || (idx_ff < lim_ff);
            acc_in = acc_sum;
            idx_in = idx_ff + POS_W'(1);
            if (idx_ff == LAST_POS) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            acc_in = acc_sum;
            if (DEPTH_IS_POW2) begin
               quo_in = acc_sum[SUM_W-1:LOG_D];
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            quo_in = recip_prod[MUL_SHIFT +: SAMPLE_BITS];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Wait until the output register is free, then hand over the item.
            if (!rsp_valid_ff || rsp_if.ready) begin
               avg_in = AVERAGE_BITS'(quo_ff);
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= sample_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            wpos_ff[i] <= '0;
         end
         full_ff <= '0;
      end else if (pos_wr_en) begin
         wpos_ff[req_ch] <= wpos_in;
         if (full_in) begin
            full_ff[req_ch] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         take_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         take_ff <= take_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      lim_ff <= lim_in;
      wrapped_ff <= wrapped_in;
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      avg_ff <= avg_in;
   end

endmodule

// ===== bench/multichannel_sample_averager_core_tb.sv =====
// Self-checking testbench for the multichannel sample averager core.
`timescale 1ns / 1ps

module multichannel_sample_averager_core_tb;
   import msa_pkg::*;

   localparam int NUM_CHANNELS = 8;
   localparam int RING_DEPTH = 16;
   localparam int SAMPLE_BITS = 12;
   localparam int RANDOM_ITEMS = 880;
   // The last stretch of random items runs with both sides always willing.
   localparam int STEADY_ITEMS = 150;
   localparam logic [SAMPLE_FIELD_BITS-1:0] SAMPLE_FULL = '1;

   // One row of the directed table. Where pinned is set, the expected
   // average is the typed-in value rather than the predictor's.
   typedef struct packed {
      logic                         cmd;
      logic [CHANNEL_BITS-1:0]      channel;
      logic [SAMPLE_FIELD_BITS-1:0] sample;
      logic                         pinned;
      logic [AVERAGE_BITS-1:0]      pinned_average;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msa_req_if req_chan ();
   msa_rsp_if rsp_chan ();

   multichannel_sample_averager_core #(
      .NUM_CHANNELS(NUM_CHANNELS),
      .RING_DEPTH(RING_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_chan),
      .rsp_if(rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted contents of every channel's ring and its write position.
   logic [SAMPLE_BITS-1:0]  ring_model [NUM_CHANNELS][RING_DEPTH];
   logic [3:0]              ring_wr_pos [NUM_CHANNELS];
   logic [AVERAGE_BITS-1:0] pending_averages [$];
   stim_row_type            directed_rows [$];

   int  error_count = 0;
   int  stores_sent = 0;
   int  reads_sent = 0;
   int  averages_checked = 0;
   bit  steady = 1'b0;
   int  sink_stall_left = 0;

   task automatic flag_error(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic clear_rings();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         ring_wr_pos[c] = '0;
         for (int k = 0; k < RING_DEPTH; k++) begin
            ring_model[c][k] = '0;
         end
      end
   endtask

   function automatic logic [AVERAGE_BITS-1:0] ring_mean(input logic [CHANNEL_BITS-1:0] ch);
      int sum;
      sum = 0;
      if (ch >= NUM_CHANNELS) begin
         return '0;
      end
      for (int k = 0; k < RING_DEPTH; k++) begin
         sum += ring_model[ch][k];
      end
      return AVERAGE_BITS'(sum / RING_DEPTH);
   endfunction

   // Applies one accepted item to the predicted rings; a read queues its average.
   task automatic predict_item(input stim_row_type row);
      if (row.cmd == CMD_STORE) begin
         if (row.channel < NUM_CHANNELS) begin
            ring_model[row.channel][ring_wr_pos[row.channel]] = row.sample[SAMPLE_BITS-1:0];
            ring_wr_pos[row.channel] = (ring_wr_pos[row.channel] == RING_DEPTH - 1) ?
                                       4'd0 : ring_wr_pos[row.channel] + 4'd1;
         end
         stores_sent++;
      end else begin
         pending_averages.push_back(row.pinned ? row.pinned_average : ring_mean(row.channel));
         reads_sent++;
      end
   endtask

   task automatic add_row(input logic cmd, input int ch, input int smp,
                          input logic pinned, input int pin_avg);
      stim_row_type row;
      row.cmd = cmd;
      row.channel = CHANNEL_BITS'(ch);
      row.sample = SAMPLE_FIELD_BITS'(smp);
      row.pinned = pinned;
      row.pinned_average = AVERAGE_BITS'(pin_avg);
      directed_rows.push_back(row);
   endtask

   // Presents one item, waits for it to be taken, then perhaps idles a while
   // with noise on the payload lines.
   task automatic send_item(input stim_row_type row);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.cmd <= row.cmd;
      req_chan.channel <= row.channel;
      req_chan.sample <= row.sample;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_item(row);
      if (!steady && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_chan.valid <= 1'b0;
         req_chan.cmd <= 1'($urandom_range(0, 1));
         req_chan.channel <= CHANNEL_BITS'($urandom_range(0, NUM_CHANNELS - 1));
         req_chan.sample <= SAMPLE_FIELD_BITS'($urandom_range(0, 4095));
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_averages();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_averages.size() != 0) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_FIELD_BITS-1:0] pick_sample();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         return '0;
      end else if (mode == 1) begin
         return SAMPLE_FULL;
      end
      return SAMPLE_FIELD_BITS'($urandom_range(0, 4095));
   endfunction

   // Result side: compares each taken average with the oldest prediction and
   // stalls in random bursts until the steady stretch begins.
   initial begin
      logic [AVERAGE_BITS-1:0] want;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (pending_averages.size() == 0) begin
               flag_error($sformatf("average %0d arrived with none expected",
                                    rsp_chan.average));
            end else begin
               want = pending_averages.pop_front();
               averages_checked++;
               if (rsp_chan.average !== want) begin
                  flag_error($sformatf("average got %0d, expected %0d",
                                       rsp_chan.average, want));
               end
            end
         end
         if (sink_stall_left > 0 && !steady) begin
            sink_stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 5) == 0) begin
            sink_stall_left = $urandom_range(1, 16) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      stim_row_type row;
      int        sent;
      int        fill_ch;
      int        guard;
      logic [SAMPLE_FIELD_BITS-1:0] fill_value;

      req_chan.valid <= 1'b0;
      req_chan.cmd <= CMD_STORE;
      req_chan.channel <= '0;
      req_chan.sample <= '0;
      clear_rings();

      // Directed table: empty rings read as zero, one full-scale sample
      // averages to a sixteenth, a full ring of full-scale samples that wraps the
      // write position, then a store that overwrites the oldest entry.
      add_row(CMD_AVERAGE, 0, 0, 1'b1, 0);
      add_row(CMD_AVERAGE, 7, 4095, 1'b1, 0);
      add_row(CMD_STORE, 5, 4095, 1'b0, 0);
      add_row(CMD_AVERAGE, 5, 0, 1'b1, 255);
      add_row(CMD_STORE, 7, 1, 1'b0, 0);
      add_row(CMD_AVERAGE, 7, 0, 1'b1, 0);
      for (int k = 0; k < RING_DEPTH; k++) begin
         add_row(CMD_STORE, 2, 4095, 1'b0, 0);
      end
      add_row(CMD_AVERAGE, 2, 0, 1'b1, 4095);
      add_row(CMD_STORE, 2, 0, 1'b0, 0);
      add_row(CMD_AVERAGE, 2, 0, 1'b0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i]);
      end
      drain_averages();

      // Random part: mostly single stores and reads, with occasional bursts
      // that fill a whole ring, mostly with one value, before reading it back.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS - STEADY_ITEMS) begin
            steady = 1'b1;
         end
         if (sent == RANDOM_ITEMS / 2) begin
            drain_averages();
         end
         row = '0;
         if ($urandom_range(0, 19) == 0) begin
            fill_ch = $urandom_range(0, NUM_CHANNELS - 1);
            fill_value = pick_sample();
            for (int k = 0; k < RING_DEPTH; k++) begin
               row.cmd = CMD_STORE;
               row.channel = CHANNEL_BITS'(fill_ch);
               row.sample = ($urandom_range(0, 3) == 0) ? pick_sample() : fill_value;
               send_item(row);
            end
            row.cmd = CMD_AVERAGE;
            row.sample = SAMPLE_FIELD_BITS'($urandom_range(0, 4095));
            send_item(row);
            sent += RING_DEPTH + 1;
         end else begin
            row.cmd = ($urandom_range(0, 9) < 7) ? CMD_STORE : CMD_AVERAGE;
            row.channel = CHANNEL_BITS'($urandom_range(0, NUM_CHANNELS - 1));
            row.sample = pick_sample();
            send_item(row);
            sent++;
         end
      end
      req_chan.valid <= 1'b0;

      guard = 0;
      while (pending_averages.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
      if (pending_averages.size() != 0) begin
         flag_error($sformatf("%0d averages never arrived", pending_averages.size()));
      end

      $display("Sent %0d store items and %0d average reads; %0d averages compared.",
               stores_sent, reads_sent, averages_checked);
      $display("Covered empty rings, full-scale fills, ring wrap and stalls on both sides.");
      if (error_count == 0) begin
         $display("[multichannel_sample_averager_core] OK");
      end else begin
         $display("[multichannel_sample_averager_core] ERROR");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("[multichannel_sample_averager_core] ERROR");
      $finish;
   end

endmodule
